FILE: hdl/smacc_pkg.sv
package smacc_pkg;

    localparam int OPCODE_W = 7;
    localparam int WORD_W   = 15;
    localparam int MAG_W    = 14;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(MAG_W);
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;

    localparam logic [OPCODE_W-1:0] OP_ADD = 7'h30;
    localparam logic [OPCODE_W-1:0] OP_SUB = 7'h31;
    localparam logic [OPCODE_W-1:0] OP_DIV = 7'h32;
    localparam logic [OPCODE_W-1:0] OP_MUL = 7'h33;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAULT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic iter;
        logic last;
    } dp_sts_t;

endpackage

FILE: hdl/smacc_ctrl.sv
module smacc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  smacc_pkg::dp_sts_t sts,
    output smacc_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;

    assign cmd.load   = accept;
    assign cmd.step   = (state_reg == S_CALC);
    assign cmd.commit = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.iter ? S_CALC : S_DONE;
                end
            end
            S_CALC:
            begin
                if (sts.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/smacc_dp.sv
module smacc_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [smacc_pkg::OPCODE_W-1:0]      opcode,
    input  logic [smacc_pkg::WORD_W-1:0]        mem_value,
    input  logic                                mem_fault,
    input  smacc_pkg::dp_cmd_t                  cmd,
    output smacc_pkg::dp_sts_t                  sts,
    output logic [smacc_pkg::WORD_W-1:0]        acc_out,
    output logic [smacc_pkg::STATUS_W-1:0]      status
);

    localparam int MW = smacc_pkg::MAG_W;
    localparam int WW = smacc_pkg::WORD_W;
    localparam int SW = WW + 1;

    function automatic logic [WW-1:0] sm_pack(input logic [WW-1:0] mag, input logic neg);
        logic [WW-1:0] r;
        if (mag == '0)
        begin
            r = '0;
        end
        else
        begin
            r = {mag[WW-1] | neg, mag[MW-1:0]};
        end
        return r;
    endfunction

    logic [WW-1:0]                      acc_reg;
    logic [WW-1:0]                      acc_next;
    logic [WW-1:0]                      res_reg;
    logic [WW-1:0]                      res_next;
    logic [smacc_pkg::STATUS_W-1:0]     st_reg;
    logic [smacc_pkg::STATUS_W-1:0]     st_next;
    logic [smacc_pkg::STATUS_W-1:0]     ost_reg;
    logic [smacc_pkg::STATUS_W-1:0]     ost_next;
    logic [WW-1:0]                      x_reg;
    logic [WW-1:0]                      x_next;
    logic [MW-1:0]                      y_reg;
    logic [MW-1:0]                      y_next;
    logic [WW-1:0]                      p_reg;
    logic [WW-1:0]                      p_next;
    logic                               div_reg;
    logic                               div_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic [smacc_pkg::CNT_W-1:0]        cnt_reg;
    logic [smacc_pkg::CNT_W-1:0]        cnt_next;

    logic [MW-1:0]                      a_mag;
    logic [MW-1:0]                      b_mag;
    logic                               is_arith;
    logic                               is_addsub;
    logic                               b_zero;
    logic                               b_neg;
    logic [SW-1:0]                      av;
    logic [SW-1:0]                      bv;
    logic [SW-1:0]                      sum;
    logic [SW-1:0]                      sum_mag;
    logic [WW-1:0]                      trial;
    logic                               ge;
    logic [WW-1:0]                      step_p;
    logic [MW-1:0]                      step_y;
    logic [WW-1:0]                      iter_mag;

    assign a_mag     = acc_reg[MW-1:0];
    assign b_mag     = mem_value[MW-1:0];
    assign b_zero    = (b_mag == '0);
    assign is_arith  = opcode inside {smacc_pkg::OP_ADD, smacc_pkg::OP_SUB,
                                      smacc_pkg::OP_DIV, smacc_pkg::OP_MUL};
    assign is_addsub = (opcode == smacc_pkg::OP_ADD) || (opcode == smacc_pkg::OP_SUB);

    assign sts.iter  = is_arith && !mem_fault && ((opcode == smacc_pkg::OP_MUL)
                       || ((opcode == smacc_pkg::OP_DIV) && !b_zero));
    assign sts.last  = (cnt_reg == '0);

    // signed add or subtract of the two magnitudes
    assign b_neg   = mem_value[MW] ^ (opcode == smacc_pkg::OP_SUB);
    assign av      = acc_reg[MW] ? (SW'(0) - SW'(a_mag)) : SW'(a_mag);
    assign bv      = b_neg ? (SW'(0) - SW'(b_mag)) : SW'(b_mag);
    assign sum     = av + bv;
    assign sum_mag = sum[SW-1] ? (SW'(0) - sum) : sum;

    // one restoring divide step or one shift-add multiply step
    assign trial = {p_reg[MW-1:0], y_reg[MW-1]};
    assign ge    = (trial >= x_reg);

    always_comb
    begin
        if (div_reg)
        begin
            step_p = ge ? (trial - x_reg) : trial;
            step_y = {y_reg[MW-2:0], ge};
        end
        else
        begin
            step_p = y_reg[0] ? (p_reg + x_reg) : p_reg;
            step_y = {1'b0, y_reg[MW-1:1]};
        end
    end

    assign iter_mag = div_reg ? {1'b0, step_y} : step_p;

    always_comb
    begin
        acc_next = acc_reg;
        res_next = res_reg;
        st_next  = st_reg;
        ost_next = ost_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        p_next   = p_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;

        if (cmd.load)
        begin
            res_next = acc_reg;
            st_next  = smacc_pkg::ST_OK;
            div_next = (opcode == smacc_pkg::OP_DIV);
            // sign only when both operands are nonzero
            neg_next = (acc_reg[MW] ^ mem_value[MW]) && (a_mag != '0) && !b_zero;
            cnt_next = smacc_pkg::CNT_W'(MW - 1);
            p_next   = '0;
            if (opcode == smacc_pkg::OP_DIV)
            begin
                x_next = WW'(b_mag);
                y_next = a_mag;
            end
            else
            begin
                x_next = WW'(a_mag);
                y_next = b_mag;
            end
            if (is_arith && mem_fault)
            begin
                st_next = smacc_pkg::ST_FAULT;
            end
            else if (is_arith && is_addsub)
            begin
                res_next = sm_pack(sum_mag[WW-1:0], sum[SW-1]);
            end
            else if ((opcode == smacc_pkg::OP_DIV) && b_zero)
            begin
                st_next = smacc_pkg::ST_DIV0;
            end
        end
        else if (cmd.step)
        begin
            p_next   = step_p;
            y_next   = step_y;
            x_next   = div_reg ? x_reg : {x_reg[WW-2:0], 1'b0};
            cnt_next = cnt_reg - smacc_pkg::CNT_W'(1);
            if (cnt_reg == '0)
            begin
                if (div_reg)
                begin
                    res_next = sm_pack(iter_mag, neg_reg);
                end
                else
                begin
                    // a nonzero product keeps its sign even when its low bits are zero
                    res_next = {iter_mag[WW-1] | neg_reg, iter_mag[MW-1:0]};
                end
            end
        end

        if (cmd.commit)
        begin
            acc_next = res_reg;
            ost_next = st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        st_reg  <= st_next;
        ost_reg <= ost_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        p_reg   <= p_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign acc_out = acc_reg;
    assign status  = ost_reg;

endmodule

FILE: hdl/sign_magnitude_accumulator_alu.sv
// 15-bit sign-magnitude accumulator alu
// commands arrive on the s_axis channel: opcode, operand word and a fetch
// fault flag; each command gives one result transfer on m_axis holding the
// accumulator after the command and a status code (0 ok, 1 fault, 2 div by 0)
// add, subtract, no-op, faulted and divide-by-zero commands skip the iterative
// unit and go straight to the done state; multiply and divide run through the
// shared 14-step shift-add / restoring-divide unit (one bit per cycle)
// one command is in work at a time; s_tready is high while the controller
// is idle, and a new command is taken even while the last result still
// waits on m_axis
// if the receiver stalls, the finished result waits in the datapath until
// the output register frees up; the accumulator updates in the same cycle
// the result is loaded into the output register
// reset clears the accumulator to zero and drops m_tvalid
module sign_magnitude_accumulator_alu
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [smacc_pkg::IN_W-1:0]  s_tdata,   // opcode, mem_value, mem_fault
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [smacc_pkg::OUT_W-1:0] m_tdata    // acc_out, status
);

    localparam int OW = smacc_pkg::OPCODE_W;
    localparam int WW = smacc_pkg::WORD_W;
    localparam int SW = smacc_pkg::STATUS_W;

    smacc_pkg::dp_cmd_t     cmd;
    smacc_pkg::dp_sts_t     sts;
    logic [WW-1:0]          acc_out;
    logic [SW-1:0]          status;

    smacc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    smacc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .opcode    (s_tdata[OW-1:0]),
        .mem_value (s_tdata[OW+WW-1:OW]),
        .mem_fault (s_tdata[OW+WW]),
        .cmd       (cmd),
        .sts       (sts),
        .acc_out   (acc_out),
        .status    (status)
    );

    assign m_tdata = {(smacc_pkg::OUT_W - WW - SW)'(0), status, acc_out};

endmodule
